FILE: hdl/bakery_ticket_lock_arbiter_unit_defines.svh
// Assertion macros used by the lock arbiter RTL.
`ifndef BAKERY_TICKET_LOCK_ARBITER_UNIT_DEFINES_SVH
`define BAKERY_TICKET_LOCK_ARBITER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every clock edge once reset has been released.
`define BKL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BKL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BKL_ASSERT(label, prop, msg)
`define BKL_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: hdl/bkl_pkg.sv
package bkl_pkg;

    // Sizing of the ticket store.
    localparam int THREADS     = 16;
    localparam int TICKET_BITS = 16;
    localparam int ADDR_W      = $clog2(THREADS);
    localparam int CNT_W       = $clog2(THREADS + 1);

    // Fixed widths of the request and result fields.
    localparam int KIND_W       = 2;
    localparam int THREAD_W     = 4;
    localparam int OWNER_W      = 4;
    localparam int TICKET_OUT_W = 16;

    localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_TAKE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POLL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // Control of the scan accumulator, one entry per cycle.
    typedef struct packed {
        logic              clear;
        logic              en;
        logic [ADDR_W-1:0] idx;
        logic [ADDR_W-1:0] thread;
        logic              in_range;
    } scan_ctl_t;

    // Totals gathered over one scan of the ticket store.
    typedef struct packed {
        logic [TICKET_BITS-1:0] max;
        logic [TICKET_BITS-1:0] best;
        logic [TICKET_BITS-1:0] mine;
        logic [ADDR_W-1:0]      who;
        logic                   found;
    } scan_res_t;

endpackage

FILE: hdl/bkl_req_if.sv
interface bkl_req_if
    import bkl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [THREAD_W-1:0] thread;

    modport source (output valid, output kind, output thread, input ready);
    modport sink   (input valid, input kind, input thread, output ready);
endinterface

FILE: hdl/bkl_rsp_if.sv
interface bkl_rsp_if
    import bkl_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    granted;
    logic [OWNER_W-1:0]      owner;
    logic                    owner_valid;
    logic [TICKET_OUT_W-1:0] ticket_value;
    logic                    overflow;

    modport source (output valid, output granted, output owner, output owner_valid,
                    output ticket_value, output overflow, input ready);
    modport sink   (input valid, input granted, input owner, input owner_valid,
                    input ticket_value, input overflow, output ready);
endinterface

FILE: hdl/bkl_ram.sv
module bkl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/bkl_scan.sv
module bkl_scan
    import bkl_pkg::*;
(
    input  logic                   clk,
    input  scan_ctl_t              ctl,
    input  logic [TICKET_BITS-1:0] data,
    output scan_res_t              res
);

    scan_res_t acc_reg;
    scan_res_t acc_next;

    // Fold one stored ticket into the running maximum and owner search.
    // The requester's own entry counts in the maximum but is kept apart
    // from the owner search, since its value changes at the end of the step.
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.en)
        begin
            if (data > acc_reg.max)
            begin
                acc_next.max = data;
            end
            if (ctl.in_range && (ctl.idx == ctl.thread))
            begin
                acc_next.mine = data;
            end
            else if ((data != '0) && (!acc_reg.found || (data < acc_reg.best)))
            begin
                acc_next.found = 1'b1;
                acc_next.best  = data;
                acc_next.who   = ctl.idx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign res = acc_reg;

endmodule

FILE: hdl/bakery_ticket_lock_arbiter_unit.sv
// Bakery-ordered lock manager for up to THREADS threads.
// Requests arrive on req (kind, thread): take a ticket, poll, or release.
// Every request gives exactly one result on rsp: whether the requester holds
// the lock, the current owner and whether there is one, the requester's
// ticket after the step and a saturation flag for takes.
// The tickets live in a single-port-read memory. Each request scans the
// store one entry per cycle through that read port, then, for a take or a
// release, writes the requester's entry back.
// Only one request is in work at a time; req.ready is high while idle.
// The result sits in an output register. If the receiver stalls, the
// finished result of the next request waits in the block until the output
// register has been emptied.
// Reset clears the per-entry valid bits, so every ticket reads as zero
// straight away; no clearing pass over the memory is needed.
`include "bakery_ticket_lock_arbiter_unit_defines.svh"

module bakery_ticket_lock_arbiter_unit
    import bkl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bkl_req_if.sink   req,
    bkl_rsp_if.source rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   dv_reg;
    logic [ADDR_W-1:0]      didx_reg;
    logic [THREADS-1:0]     valid_reg, valid_next;
    logic [KIND_W-1:0]      kind_reg;
    logic [ADDR_W-1:0]      thread_reg;
    logic                   in_range_reg;

    logic                    res_granted_reg;
    logic [ADDR_W-1:0]       res_owner_reg;
    logic                    res_owner_valid_reg;
    logic [TICKET_BITS-1:0]  res_ticket_reg;
    logic                    res_ovf_reg;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_granted_reg;
    logic [OWNER_W-1:0]      out_owner_reg;
    logic                    out_owner_valid_reg;
    logic [TICKET_OUT_W-1:0] out_ticket_reg;
    logic                    out_ovf_reg;

    logic                   accept;
    logic                   ram_re;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [TICKET_BITS-1:0] ram_rdata;
    logic [TICKET_BITS-1:0] scan_data;
    scan_ctl_t              scan_ctl;
    scan_res_t              scan_res;

    logic [TICKET_BITS-1:0] new_ticket;
    logic                   calc_ovf;
    logic                   req_wins;
    logic                   load_out;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);

    // Ticket store.
    assign ram_raddr = cnt_reg[ADDR_W-1:0];
    assign ram_re    = (state_reg == ST_SCAN) && (cnt_reg < CNT_W'(THREADS));

    bkl_ram #(
        .WIDTH (TICKET_BITS),
        .DEPTH (THREADS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (thread_reg),
        .wdata (new_ticket),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // An entry never written since reset reads as zero.
    assign scan_data = valid_reg[didx_reg] ? ram_rdata : '0;

    assign scan_ctl.clear    = accept;
    assign scan_ctl.en       = dv_reg;
    assign scan_ctl.idx      = didx_reg;
    assign scan_ctl.thread   = thread_reg;
    assign scan_ctl.in_range = in_range_reg;

    bkl_scan u_scan (
        .clk  (clk),
        .ctl  (scan_ctl),
        .data (scan_data),
        .res  (scan_res)
    );

    // New ticket of the requester once the scan is complete.
    always_comb
    begin
        calc_ovf = 1'b0;
        case (kind_reg)
            KIND_TAKE:
            begin
                if (scan_res.max == TICKET_MAX)
                begin
                    new_ticket = TICKET_MAX;
                    calc_ovf   = in_range_reg;
                end
                else
                begin
                    new_ticket = scan_res.max + TICKET_BITS'(1);
                end
            end
            KIND_RELEASE:
            begin
                new_ticket = '0;
            end
            KIND_POLL:
            begin
                new_ticket = scan_res.mine;
            end
            default:
            begin
                new_ticket = scan_res.mine;
            end
        endcase
    end

    // The requester owns the lock if its ticket beats every other one,
    // equal tickets going to the lower thread id.
    assign req_wins = in_range_reg && (new_ticket != '0) &&
                      (!scan_res.found || (new_ticket < scan_res.best) ||
                       ((new_ticket == scan_res.best) && (thread_reg < scan_res.who)));

    assign ram_we = (state_reg == ST_CALC) && in_range_reg &&
                    ((kind_reg == KIND_TAKE) || (kind_reg == KIND_RELEASE));

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    // Sequencer and valid bits.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == CNT_W'(THREADS))
                begin
                    state_next = ST_CALC;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_CALC:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (ram_we)
        begin
            valid_next[thread_reg] = 1'b1;
        end
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            dv_reg        <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            dv_reg        <= ram_re;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        didx_reg <= ram_raddr;
        if (accept)
        begin
            kind_reg     <= req.kind;
            thread_reg   <= ADDR_W'(req.thread);
            in_range_reg <= (int'(req.thread) < THREADS);
        end
        if (state_reg == ST_CALC)
        begin
            res_granted_reg     <= req_wins;
            res_owner_reg       <= req_wins ? thread_reg : scan_res.who;
            res_owner_valid_reg <= req_wins || scan_res.found;
            res_ticket_reg      <= in_range_reg ? new_ticket : '0;
            res_ovf_reg         <= calc_ovf;
        end
        if (load_out)
        begin
            out_granted_reg     <= res_granted_reg;
            out_owner_reg       <= OWNER_W'(res_owner_reg);
            out_owner_valid_reg <= res_owner_valid_reg;
            out_ticket_reg      <= TICKET_OUT_W'(res_ticket_reg);
            out_ovf_reg         <= res_ovf_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.granted      = out_granted_reg;
    assign rsp.owner        = out_owner_reg;
    assign rsp.owner_valid  = out_owner_valid_reg;
    assign rsp.ticket_value = out_ticket_reg;
    assign rsp.overflow     = out_ovf_reg;

    // Checks on the sequencer and on the results.
    `BKL_ASSERT(a_accept_starts_scan, accept |=> (state_reg == ST_SCAN), "scan not started")
    `BKL_ASSERT(a_read_data_in_scan, dv_reg |-> (state_reg == ST_SCAN), "stray read data")
    `BKL_ASSERT(a_grant_has_owner, (rsp.valid && rsp.granted) |-> rsp.owner_valid, "no owner")
    `BKL_ASSERT(a_ovf_at_max, (rsp.valid && rsp.overflow) |-> (&rsp.ticket_value), "low ticket")

endmodule
